@@ rtl/dsfb_pkg.sv @@
// Package: framing constants, queue entry type and queue status type.
package dsfb_pkg;

  localparam logic [7:0] DLE_BYTE    = 8'h10;
  localparam logic [7:0] STX_BYTE    = 8'h02;
  localparam logic [7:0] ETX_BYTE    = 8'h03;
  localparam logic [7:0] SUM_MASK    = 8'hff;
  localparam logic [7:0] MAX_PAYLOAD = 8'd251;
  localparam logic [7:0] LEN_EXTRA   = 8'd2;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  typedef struct packed {
    logic       opening;
    logic [7:0] len_byte;
    logic [7:0] data;
    logic       closing;
    logic [7:0] sum;
  } desc_t;

  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

@@ rtl/dsfb_front.sv @@
// Front end: accepts payload items, keeps frame state and builds queue entries.
module dsfb_front import dsfb_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    payload_byte_i,
  input  logic [7:0]    payload_length_i,
  input  queue_status_t q_status_i,
  output logic          push_o,
  output desc_t         push_desc_o
);

  logic       in_frame_q, in_frame_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic [7:0] running_sum_q, running_sum_d;
  logic [7:0] len_sat;
  logic [7:0] left_base;
  logic [7:0] sum_base;
  logic [7:0] sum_new;
  logic [7:0] left_new;
  logic       accept;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;
  assign push_o     = accept;

  always_comb begin
    if (payload_length_i == 8'd0) begin
      len_sat = 8'd1;
    end else if (payload_length_i > MAX_PAYLOAD) begin
      len_sat = MAX_PAYLOAD;
    end else begin
      len_sat = payload_length_i;
    end
    left_base = in_frame_q ? bytes_left_q : len_sat;
    sum_base  = in_frame_q ? running_sum_q : 8'd0;
    sum_new   = (sum_base + payload_byte_i) & SUM_MASK;
    left_new  = left_base - 8'd1;

    push_desc_o.opening  = !in_frame_q;
    push_desc_o.len_byte = len_sat + LEN_EXTRA;
    push_desc_o.data     = payload_byte_i;
    push_desc_o.closing  = (left_new == 8'd0);
    push_desc_o.sum      = sum_new;

    in_frame_d    = in_frame_q;
    bytes_left_d  = bytes_left_q;
    running_sum_d = running_sum_q;
    if (accept) begin
      if (left_new == 8'd0) begin
        in_frame_d    = 1'b0;
        bytes_left_d  = 8'd0;
        running_sum_d = 8'd0;
      end else begin
        in_frame_d    = 1'b1;
        bytes_left_d  = left_new;
        running_sum_d = sum_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q    <= 1'b0;
      bytes_left_q  <= 8'd0;
      running_sum_q <= 8'd0;
    end else begin
      in_frame_q    <= in_frame_d;
      bytes_left_q  <= bytes_left_d;
      running_sum_q <= running_sum_d;
    end
  end

endmodule

@@ rtl/dsfb_queue.sv @@
// Short queue of entries between front end and back end.
module dsfb_queue import dsfb_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  desc_t         push_desc_i,
  input  logic          pop_i,
  output desc_t         head_o,
  output queue_status_t status_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  desc_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign status_o.full  = (count_q == CNT_W'(DEPTH));
  assign status_o.valid = (count_q != '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && status_o.valid;
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ rtl/dsfb_back.sv @@
// Back end: steps through the output bytes of each entry into an output register.
module dsfb_back import dsfb_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  desc_t         head_i,
  input  queue_status_t q_status_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_byte_o,
  output logic          run_last_o,
  output logic          frame_end_o
);

  localparam logic [3:0] STEP_DLE_OPEN = 4'd0;
  localparam logic [3:0] STEP_STX      = 4'd1;
  localparam logic [3:0] STEP_LEN      = 4'd2;
  localparam logic [3:0] STEP_LEN_DUP  = 4'd3;
  localparam logic [3:0] STEP_DATA     = 4'd4;
  localparam logic [3:0] STEP_DATA_DUP = 4'd5;
  localparam logic [3:0] STEP_SUM      = 4'd6;
  localparam logic [3:0] STEP_SUM_DUP  = 4'd7;
  localparam logic [3:0] STEP_DLE_END  = 4'd8;
  localparam logic [3:0] STEP_ETX      = 4'd9;
  localparam int unsigned NUM_STEPS    = 10;

  logic [3:0]           step_q, step_d;
  logic [NUM_STEPS-1:0] active;
  logic [3:0]           cur;
  logic                 found;
  logic                 last;
  logic                 emit;
  logic [7:0]           byte_sel;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_byte_q;
  logic                 run_last_q;
  logic                 frame_end_q;

  always_comb begin
    active                = '0;
    active[STEP_DLE_OPEN] = head_i.opening;
    active[STEP_STX]      = head_i.opening;
    active[STEP_LEN]      = head_i.opening;
    active[STEP_LEN_DUP]  = head_i.opening && (head_i.len_byte == DLE_BYTE);
    active[STEP_DATA]     = 1'b1;
    active[STEP_DATA_DUP] = (head_i.data == DLE_BYTE);
    active[STEP_SUM]      = head_i.closing;
    active[STEP_SUM_DUP]  = head_i.closing && (head_i.sum == DLE_BYTE);
    active[STEP_DLE_END]  = head_i.closing;
    active[STEP_ETX]      = head_i.closing;
  end

  // Pick the first active step at or after the resume point; last if none follows.
  always_comb begin
    cur   = STEP_DATA;
    found = 1'b0;
    last  = 1'b1;
    for (int i = 0; i < NUM_STEPS; i++) begin
      if (found && active[i]) begin
        last = 1'b0;
      end
      if (!found && active[i] && (4'(i) >= step_q)) begin
        cur   = 4'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    case (cur)
      STEP_DLE_OPEN: byte_sel = DLE_BYTE;
      STEP_STX:      byte_sel = STX_BYTE;
      STEP_LEN:      byte_sel = head_i.len_byte;
      STEP_LEN_DUP:  byte_sel = head_i.len_byte;
      STEP_DATA:     byte_sel = head_i.data;
      STEP_DATA_DUP: byte_sel = head_i.data;
      STEP_SUM:      byte_sel = head_i.sum;
      STEP_SUM_DUP:  byte_sel = head_i.sum;
      STEP_DLE_END:  byte_sel = DLE_BYTE;
      STEP_ETX:      byte_sel = ETX_BYTE;
      default:       byte_sel = head_i.data;
    endcase
  end

  assign emit  = q_status_i.valid && (!out_valid_q || !out_stall_i);
  assign pop_o = emit && last;

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (emit) begin
      out_valid_d = 1'b1;
      step_d      = last ? STEP_DLE_OPEN : cur + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_DLE_OPEN;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q  <= byte_sel;
      run_last_q  <= last;
      frame_end_q <= (cur == STEP_ETX);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;
  assign frame_end_o = frame_end_q;

endmodule

@@ rtl/dle_stuffed_frame_builder_unit.sv @@
// Top level: DLE/STX/ETX byte-stuffing framer with front end, queue and back end.
//
//   channel  direction  handshake             fields
//   in       input      in_valid_i/in_stall_o  payload_byte_i, payload_length_i
//   out      output     out_valid_o/out_stall_i out_byte_o, run_last_o, frame_end_o
//
// An input item is taken each cycle while the queue has room; the back end emits one
// output byte per cycle unless stalled or the queue is empty; an item yields 1 to 9
// bytes (1 for a plain middle byte, 2 for a doubled DLE, 9 for a one-byte DLE frame).
// Reset clears frame state, queue pointers and the output valid; no clearing pass.
// Output stall holds the output register; input stall rises only when the queue is full.
module dle_stuffed_frame_builder_unit import dsfb_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] payload_byte_i,
  input  logic [7:0] payload_length_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       frame_end_o
);

  queue_status_t q_status;
  desc_t         push_desc;
  desc_t         head;
  logic          push;
  logic          pop;

  dsfb_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .payload_byte_i   (payload_byte_i),
    .payload_length_i (payload_length_i),
    .q_status_i       (q_status),
    .push_o           (push),
    .push_desc_o      (push_desc)
  );

  dsfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  dsfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .frame_end_o (frame_end_o)
  );

  a_end_is_last_etx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> run_last_o && (out_byte_o == ETX_BYTE))
    else $error("frame end not on a final ETX");

  a_next_frame_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && frame_end_o |=> !out_valid_o || (out_byte_o == DLE_BYTE))
    else $error("byte after frame end is not DLE");

  a_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.full |-> q_status.valid && in_stall_o)
    else $error("queue full without entries or without input stall");

endmodule
